>>> design/kwmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwmq_pkg
// Shared types, command codes and the entry ordering rule of the merge queue.
// ----------------------------------------------------------------------------
package kwmq_pkg;

    localparam logic [1:0] CMD_INSERT  = 2'd0;
    localparam logic [1:0] CMD_POP     = 2'd1;
    localparam logic [1:0] CMD_REPLACE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        OP_NOP     = 2'd0,
        OP_INSERT  = 2'd1,
        OP_POP     = 2'd2,
        OP_REPLACE = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]          cmd;
        logic signed [31:0]  value;
        logic [3:0]          list_index;
    } t_in_req;

    typedef struct packed {
        logic                popped;
        logic signed [31:0]  out_value;
        logic [3:0]          out_list;
        logic [4:0]          occupancy;
        logic [1:0]          status;
    } t_out_rsp;

    typedef struct packed {
        logic                valid;
        logic signed [31:0]  value;
        logic [3:0]          src;
    } t_entry;

    typedef struct packed {
        t_op    op;
        t_entry item;
    } t_cell_ctrl;

    localparam t_entry EMPTY_ENTRY = '0;

    // a leaves ahead of b: smaller signed value, then lower stream index
    function automatic logic goes_first(input t_entry a, input t_entry b);
        logic lt;
        logic eq;
        lt = a.value < b.value;
        eq = a.value == b.value;
        return lt || (eq && (a.src < b.src));
    endfunction

endpackage

>>> design/kwmq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwmq_cell
// One slot of the sorted cell row: keeps its entry, takes the new entry, or
// takes a neighbor's entry so the row stays sorted after insert, pop, replace.
// ----------------------------------------------------------------------------
module kwmq_cell
    import kwmq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_entry     i_left,
    input  t_entry     i_right,
    input  logic       i_left_ins,
    output t_entry     o_entry,
    output logic       o_ins
);

    logic               r_valid;
    logic signed [31:0] r_value;
    logic [3:0]         r_src;
    t_entry             w_own;
    t_entry             w_eff_own;
    t_entry             w_eff_left;
    t_entry             n_entry;
    logic               w_shift;
    logic               w_ins;

    assign w_own      = '{valid: r_valid, value: r_value, src: r_src};
    assign w_shift    = (i_ctrl.op == OP_POP) || (i_ctrl.op == OP_REPLACE);
    assign w_eff_own  = w_shift ? i_right : w_own;
    assign w_eff_left = w_shift ? w_own : i_left;
    assign w_ins      = !w_eff_own.valid || goes_first(i_ctrl.item, w_eff_own);

    always_comb begin
        unique case (i_ctrl.op)
            OP_NOP: begin
                n_entry = w_own;
            end
            OP_POP: begin
                n_entry = i_right;
            end
            default: begin
                if (!w_ins) begin
                    n_entry = w_eff_own;
                end else if (i_left_ins) begin
                    n_entry = w_eff_left;
                end else begin
                    n_entry = i_ctrl.item;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_entry.value;
        r_src   <= n_entry.src;
    end

    assign o_entry = w_own;
    assign o_ins   = w_ins;

endmodule

>>> design/k_way_merge_min_queue_core.sv
`timescale 1ns / 1ps
// result: registered, valid in the cycle after its request is accepted
// throughput: one request per cycle while results are taken; every cell of the
// row compares against the new entry and shifts in the same cycle
// reset: synchronous, clears the entry count, every cell's valid bit and the
// result valid flag; entry data is not cleared and no clearing pass is needed
// ----------------------------------------------------------------------------
// k_way_merge_min_queue_core
// Min-priority queue for a k-way merge, built as a sorted row of cells with
// the smallest entry always held in the first cell.
// ----------------------------------------------------------------------------
module k_way_merge_min_queue_core
    import kwmq_pkg::*;
#(
    parameter int MAX_LISTS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_rsp o_out_rsp
);

    localparam int CW = $clog2(MAX_LISTS + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    t_out_rsp      r_out;
    t_out_rsp      n_out;
    t_cell_ctrl    w_ctrl;
    logic          w_accept;
    t_entry        w_entry [MAX_LISTS];
    logic          w_ins   [MAX_LISTS];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        w_ctrl.op   = OP_NOP;
        w_ctrl.item = '{valid: 1'b1, value: i_in_req.value, src: i_in_req.list_index};
        n_count     = r_count;
        n_out       = '0;
        unique case (i_in_req.cmd) inside
            CMD_INSERT: begin
                if (r_count == CW'(MAX_LISTS)) begin
                    n_out.status = ST_FULL;
                end else begin
                    w_ctrl.op = OP_INSERT;
                    n_count   = r_count + 1'b1;
                end
            end
            CMD_POP, CMD_REPLACE: begin
                if (r_count == '0) begin
                    n_out.status = ST_EMPTY;
                end else begin
                    n_out.popped    = 1'b1;
                    n_out.out_value = w_entry[0].value;
                    n_out.out_list  = w_entry[0].src;
                    if (i_in_req.cmd == CMD_POP) begin
                        w_ctrl.op = OP_POP;
                        n_count   = r_count - 1'b1;
                    end else begin
                        w_ctrl.op = OP_REPLACE;
                    end
                end
            end
            default: begin
            end
        endcase
        n_out.occupancy = 5'(n_count);
        if (!w_accept) begin
            w_ctrl.op = OP_NOP;
        end
    end

    generate
        for (genvar g = 0; g < MAX_LISTS; g++) begin : g_cell
            t_entry w_left;
            t_entry w_right;
            logic   w_left_ins;
            if (g == 0) begin : g_first
                assign w_left     = EMPTY_ENTRY;
                assign w_left_ins = 1'b0;
            end else begin : g_mid
                assign w_left     = w_entry[g-1];
                assign w_left_ins = w_ins[g-1];
            end
            if (g == MAX_LISTS - 1) begin : g_last
                assign w_right = EMPTY_ENTRY;
            end else begin : g_inner
                assign w_right = w_entry[g+1];
            end
            kwmq_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctrl     (w_ctrl),
                .i_left     (w_left),
                .i_right    (w_right),
                .i_left_ins (w_left_ins),
                .o_entry    (w_entry[g]),
                .o_ins      (w_ins[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

endmodule

>>> bench/tb_k_way_merge_min_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_k_way_merge_min_queue_core
// Self-checking bench for the merge min-queue. A short directed list hits
// empty, full and tie cases, then random merge rounds (stream heads, then
// refills of ascending values, then a drain) mixed with bursts of random
// commands. Each accepted request is run through a behavioral model of the
// queue and the response is compared field by field. Both sides throttle at
// random, with one long output hold-off and one sender pause until drained.
// ----------------------------------------------------------------------------
module tb_k_way_merge_min_queue_core;
    import kwmq_pkg::*;

    localparam int         QUEUE_DEPTH  = 16;
    localparam int         TARGET_ITEMS = 1500;
    localparam int         CYCLE_LIMIT  = 300000;
    localparam int         HOLD_CYCLES  = 80;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    t_in_req  req_data = '0;
    logic     rsp_ready = 1'b0;
    logic     in_ready;
    logic     rsp_valid;
    t_out_rsp rsp_data;

    t_in_req  pending_reqs[$];
    t_out_rsp expected_rsps[$];
    t_entry   held_entries[$];

    int n_real = 0;
    int gen_count = 0;
    int total_reqs = 0;
    int n_accepted = 0;
    int n_rsp = 0;
    int n_errors = 0;
    int n_cycles = 0;
    int pause_at = 0;
    int hold_at = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    k_way_merge_min_queue_core #(
        .MAX_LISTS(QUEUE_DEPTH)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (req_valid),
        .o_in_ready (in_ready),
        .i_in_req   (req_data),
        .o_out_valid(rsp_valid),
        .i_out_ready(rsp_ready),
        .o_out_rsp  (rsp_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic bit leaves_first(input t_entry a, input t_entry b);
        if ($signed(a.value) != $signed(b.value)) begin
            return $signed(a.value) < $signed(b.value);
        end
        return a.src < b.src;
    endfunction

    // applies one request to the behavioral queue and returns its response
    function automatic t_out_rsp merge_queue_step(input t_in_req r);
        t_out_rsp rsp;
        t_entry   e;
        int       best;
        rsp = '0;
        e.valid = 1'b1;
        e.value = r.value;
        e.src   = r.list_index;
        case (r.cmd)
            CMD_INSERT: begin
                if (held_entries.size() >= QUEUE_DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    held_entries.push_back(e);
                end
            end
            CMD_POP, CMD_REPLACE: begin
                if (held_entries.size() == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    best = 0;
                    for (int i = 1; i < held_entries.size(); i++) begin
                        if (leaves_first(held_entries[i], held_entries[best])) begin
                            best = i;
                        end
                    end
                    rsp.popped    = 1'b1;
                    rsp.out_value = held_entries[best].value;
                    rsp.out_list  = held_entries[best].src;
                    held_entries.delete(best);
                    if (r.cmd == CMD_REPLACE) begin
                        held_entries.push_back(e);
                    end
                end
            end
            default: begin
            end
        endcase
        rsp.occupancy = 5'(held_entries.size());
        return rsp;
    endfunction

    task automatic add_req(input logic [1:0] cmd, input logic [31:0] value,
                           input logic [3:0] idx);
        t_in_req r;
        r.cmd        = cmd;
        r.value      = value;
        r.list_index = idx;
        pending_reqs.push_back(r);
        if (cmd != CMD_UNUSED) begin
            n_real++;
        end
        if (cmd == CMD_INSERT && gen_count < QUEUE_DEPTH) begin
            gen_count++;
        end else if (cmd == CMD_POP && gen_count > 0) begin
            gen_count--;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_errors++;
        end
    endtask

    function automatic int send_idle_pct();
        if (n_accepted * 3 < total_reqs) return 12;
        if (n_accepted * 3 < total_reqs * 2) return 48;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (n_accepted * 3 < total_reqs) return 48;
        if (n_accepted * 3 < total_reqs * 2) return 12;
        return 0;
    endfunction

    // request driver
    always @(posedge clk) begin
        t_in_req nxt_req;
        logic    nxt_valid;
        if (!rst_n) begin
            req_valid <= 1'b0;
        end else begin
            nxt_req   = req_data;
            nxt_valid = req_valid;
            if (req_valid && in_ready) begin
                expected_rsps.push_back(merge_queue_step(req_data));
                n_accepted++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && pending_reqs.size() != 0
                && !(n_accepted == pause_at && expected_rsps.size() != 0)
                && $urandom_range(0, 99) >= send_idle_pct()) begin
                nxt_req   = pending_reqs.pop_front();
                nxt_valid = 1'b1;
            end
            req_valid <= nxt_valid;
            req_data  <= nxt_req;
        end
    end

    // response monitor
    always @(posedge clk) begin
        t_out_rsp want;
        if (!rst_n) begin
            rsp_ready <= 1'b0;
        end else begin
            if (rsp_valid && rsp_ready) begin
                n_rsp++;
                if (expected_rsps.size() == 0) begin
                    $error("response with no request outstanding");
                    n_errors++;
                end else begin
                    want = expected_rsps.pop_front();
                    check_field("popped", 32'(want.popped), 32'(rsp_data.popped));
                    check_field("out_value", want.out_value, rsp_data.out_value);
                    check_field("out_list", 32'(want.out_list), 32'(rsp_data.out_list));
                    check_field("occupancy", 32'(want.occupancy),
                                32'(rsp_data.occupancy));
                    check_field("status", 32'(want.status), 32'(rsp_data.status));
                end
            end
            if (hold_left != 0) begin
                hold_left--;
            end else if (!hold_done && n_rsp >= hold_at) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            rsp_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct());
        end
    end

    always @(posedge clk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        logic [31:0] stream_tail[QUEUE_DEPTH];
        logic [3:0]  stream_id[QUEUE_DEPTH];
        int          k;
        int          n;
        int          j;
        int          sel;

        // directed: empty, extremes, ties, full
        add_req(CMD_POP, 32'd0, 4'd0);
        add_req(CMD_REPLACE, 32'd5, 4'd3);
        add_req(CMD_UNUSED, 32'hffff_ffff, 4'hf);
        add_req(CMD_INSERT, 32'h8000_0000, 4'd15);
        add_req(CMD_INSERT, 32'h7fff_ffff, 4'd0);
        add_req(CMD_INSERT, 32'h0000_0000, 4'd0);
        add_req(CMD_INSERT, 32'hffff_ffff, 4'd15);
        add_req(CMD_INSERT, 32'd7, 4'd9);
        add_req(CMD_INSERT, 32'd7, 4'd2);
        add_req(CMD_INSERT, 32'd7, 4'd2);
        add_req(CMD_INSERT, 32'h8000_0000, 4'd0);
        add_req(CMD_INSERT, 32'h7fff_ffff, 4'd15);
        for (int i = 0; i < 7; i++) begin
            add_req(CMD_INSERT, $urandom, 4'($urandom_range(0, 15)));
        end
        add_req(CMD_INSERT, 32'd1, 4'd1);
        add_req(CMD_REPLACE, 32'h8000_0000, 4'd5);
        add_req(CMD_UNUSED, 32'd0, 4'd0);
        for (int i = 0; i < 3; i++) begin
            add_req(CMD_POP, $urandom, 4'($urandom_range(0, 15)));
        end

        while (n_real < TARGET_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
                n = $urandom_range(5, 30);
                for (int i = 0; i < n; i++) begin
                    sel = $urandom_range(0, 9);
                    add_req(sel < 5 ? CMD_INSERT : sel < 7 ? CMD_POP :
                            sel < 9 ? CMD_REPLACE : CMD_UNUSED,
                            $urandom, 4'($urandom_range(0, 15)));
                end
            end else begin
                // merge round: stream heads, refills, drain
                k = $urandom_range(2, QUEUE_DEPTH);
                for (int i = 0; i < k; i++) begin
                    stream_id[i]   = 4'($urandom_range(0, 15));
                    stream_tail[i] = ($urandom_range(0, 3) == 0) ? $urandom
                                                                 : $urandom_range(0, 200) - 100;
                    add_req(CMD_INSERT, stream_tail[i], stream_id[i]);
                end
                n = $urandom_range(10, 60);
                for (int i = 0; i < n; i++) begin
                    j = $urandom_range(0, k - 1);
                    stream_tail[j] = stream_tail[j] + $urandom_range(0, 4);
                    add_req(CMD_REPLACE, stream_tail[j], stream_id[j]);
                end
                while (gen_count > 0) begin
                    add_req(CMD_POP, $urandom, 4'($urandom_range(0, 15)));
                end
                if ($urandom_range(0, 1) == 0) begin
                    add_req($urandom_range(0, 1) ? CMD_POP : CMD_REPLACE,
                            $urandom, 4'($urandom_range(0, 15)));
                end
            end
        end

        total_reqs = pending_reqs.size();
        hold_at    = (total_reqs * 4) / 5;
        pause_at   = (total_reqs * 9) / 10;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0) begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        if (n_errors == 0 && expected_rsps.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
